FILE: rtl/jpfk_pkg.sv
// jpfk_pkg: shared widths, micro-op types and helper functions for the
// forward kinematics block. No dependencies; used by every rtl file.
package jpfk_pkg;

  // skeleton size and item layout
  localparam int unsigned MAX_JOINTS = 64;
  localparam int unsigned JIDX_W     = $clog2(MAX_JOINTS);
  localparam int unsigned QW         = 16;   // Q2.14 quaternion component
  localparam int unsigned PW         = 32;   // Q16.16 position component
  localparam int unsigned S_TDATA_W  = 176;
  localparam int unsigned M_TDATA_W  = 168;
  localparam int unsigned ENTRY_W    = 4 * QW + 3 * PW;

  // datapath widths
  localparam int unsigned TQW    = 20;  // rounded quaternion product component
  localparam int unsigned WIDE_W = 40;  // wide multiplier operand
  localparam int unsigned NAR_W  = 20;  // narrow multiplier operand
  localparam int unsigned ACC_W  = WIDE_W + NAR_W;
  localparam int unsigned SUM_W  = 39;  // sum of squares
  localparam int unsigned RND_SH = 14;
  localparam int unsigned SATW   = 41;  // width for 32-bit saturating sums
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (RND_SH - 1);

  // micro-program lengths
  localparam int unsigned QMUL_STEPS = 16;
  localparam int unsigned ROT_STEPS  = 22;
  localparam int unsigned SQ_STEPS   = 4;

  // negative terms of the hamilton product, bit index = 4*out + term
  localparam logic [15:0] QMUL_NEG = 16'b0100_0010_1000_1110;

  typedef enum logic [2:0] {WK_LQ, WK_LP, WK_PQ, WK_TQ, WK_D, WK_C} wide_kind_e;
  typedef enum logic [1:0] {NK_DQ, NK_PQ, NK_TQ, NK_A} nar_kind_e;
  typedef enum logic [2:0] {DK_TQ, DK_A, DK_D, DK_C, DK_OP, DK_S} dst_kind_e;

  typedef struct packed {
    logic       neg;
    logic       dbl;
    logic       clr;
    logic       last;
    dst_kind_e  dst;
    logic [1:0] dst_idx;
  } mac_ctl_t;

  typedef struct packed {
    wide_kind_e wk;
    logic [1:0] wi;
    nar_kind_e  nk;
    logic [1:0] ni;
    mac_ctl_t   ctl;
  } uop_t;

  typedef struct packed {
    logic       valid;
    dst_kind_e  dst;
    logic [1:0] idx;
  } mac_wb_t;

  function automatic uop_t mk_uop(wide_kind_e wk, logic [1:0] wi, nar_kind_e nk,
                                  logic [1:0] ni, logic neg, logic dbl, logic clr,
                                  logic last, dst_kind_e dst, logic [1:0] di);
    uop_t u;
    u.wk          = wk;
    u.wi          = wi;
    u.nk          = nk;
    u.ni          = ni;
    u.ctl.neg     = neg;
    u.ctl.dbl     = dbl;
    u.ctl.clr     = clr;
    u.ctl.last    = last;
    u.ctl.dst     = dst;
    u.ctl.dst_idx = di;
    return u;
  endfunction

  // out[i] += sign * nar[k] * lq[i^k]
  function automatic uop_t qmul_uop(logic [3:0] step, nar_kind_e nk);
    logic [1:0] i;
    logic [1:0] k;
    i = step[3:2];
    k = step[1:0];
    return mk_uop(WK_LQ, i ^ k, nk, k, QMUL_NEG[step], 1'b0, k == 2'd0, k == 2'd3,
                  DK_TQ, i);
  endfunction

  // sum of squares of the rounded product
  function automatic uop_t sq_uop(logic [1:0] k);
    return mk_uop(WK_TQ, k, NK_TQ, k, 1'b0, 1'b0, k == 2'd0, k == 2'd3, DK_S, 2'd0);
  endfunction

  // rotation of the local position by the parent orientation
  function automatic uop_t rot_uop(logic [4:0] step);
    uop_t u;
    u = '0;
    case (step)
      // a = w^2 - |u|^2
      5'd0:  u = mk_uop(WK_PQ, 2'd0, NK_PQ, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DK_A, 2'd0);
      5'd1:  u = mk_uop(WK_PQ, 2'd1, NK_PQ, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0, DK_A, 2'd0);
      5'd2:  u = mk_uop(WK_PQ, 2'd2, NK_PQ, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0, DK_A, 2'd0);
      5'd3:  u = mk_uop(WK_PQ, 2'd3, NK_PQ, 2'd3, 1'b1, 1'b0, 1'b0, 1'b1, DK_A, 2'd0);
      // d = u . v
      5'd4:  u = mk_uop(WK_LP, 2'd0, NK_PQ, 2'd1, 1'b0, 1'b0, 1'b1, 1'b0, DK_D, 2'd0);
      5'd5:  u = mk_uop(WK_LP, 2'd1, NK_PQ, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0, DK_D, 2'd0);
      5'd6:  u = mk_uop(WK_LP, 2'd2, NK_PQ, 2'd3, 1'b0, 1'b0, 1'b0, 1'b1, DK_D, 2'd0);
      // c = u x v
      5'd7:  u = mk_uop(WK_LP, 2'd2, NK_PQ, 2'd2, 1'b0, 1'b0, 1'b1, 1'b0, DK_C, 2'd0);
      5'd8:  u = mk_uop(WK_LP, 2'd1, NK_PQ, 2'd3, 1'b1, 1'b0, 1'b0, 1'b1, DK_C, 2'd0);
      5'd9:  u = mk_uop(WK_LP, 2'd0, NK_PQ, 2'd3, 1'b0, 1'b0, 1'b1, 1'b0, DK_C, 2'd1);
      5'd10: u = mk_uop(WK_LP, 2'd2, NK_PQ, 2'd1, 1'b1, 1'b0, 1'b0, 1'b1, DK_C, 2'd1);
      5'd11: u = mk_uop(WK_LP, 2'd1, NK_PQ, 2'd1, 1'b0, 1'b0, 1'b1, 1'b0, DK_C, 2'd2);
      5'd12: u = mk_uop(WK_LP, 2'd0, NK_PQ, 2'd2, 1'b1, 1'b0, 1'b0, 1'b1, DK_C, 2'd2);
      // r = a*v + 2*d*u + 2*w*c
      5'd13: u = mk_uop(WK_LP, 2'd0, NK_A,  2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DK_OP, 2'd0);
      5'd14: u = mk_uop(WK_D,  2'd0, NK_PQ, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0, DK_OP, 2'd0);
      5'd15: u = mk_uop(WK_C,  2'd0, NK_PQ, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, DK_OP, 2'd0);
      5'd16: u = mk_uop(WK_LP, 2'd1, NK_A,  2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DK_OP, 2'd1);
      5'd17: u = mk_uop(WK_D,  2'd0, NK_PQ, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0, DK_OP, 2'd1);
      5'd18: u = mk_uop(WK_C,  2'd1, NK_PQ, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, DK_OP, 2'd1);
      5'd19: u = mk_uop(WK_LP, 2'd2, NK_A,  2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DK_OP, 2'd2);
      5'd20: u = mk_uop(WK_D,  2'd0, NK_PQ, 2'd3, 1'b0, 1'b1, 1'b0, 1'b0, DK_OP, 2'd2);
      5'd21: u = mk_uop(WK_C,  2'd2, NK_PQ, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, DK_OP, 2'd2);
      default: u = '0;
    endcase
    return u;
  endfunction

  function automatic logic signed [QW-1:0] sat16(logic signed [TQW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > TQW'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -TQW'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [PW-1:0] sat32(logic signed [SATW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > SATW'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < -SATW'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/jpfk_mac.sv
// jpfk_mac: shared signed multiply-accumulate unit, one product per cycle.
// Registered product, then accumulate; depends on jpfk_pkg.
module jpfk_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 issue_i,
  input  jpfk_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [jpfk_pkg::WIDE_W-1:0]   wide_i,
  input  logic signed [jpfk_pkg::NAR_W-1:0]    nar_i,
  output logic signed [jpfk_pkg::ACC_W-1:0]    acc_o,
  output jpfk_pkg::mac_wb_t                    wb_o,
  output logic                                 busy_o
);
  import jpfk_pkg::*;

  logic                    v1_q;
  logic                    v2_q;
  mac_ctl_t                ctl1_q;
  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  dst_kind_e               dst2_q;
  logic [1:0]              idx2_q;
  logic signed [ACC_W-1:0] scaled;
  logic signed [ACC_W-1:0] term;

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q & ctl1_q.last;
    end
  end

  // term scaling and sign
  always_comb begin
    scaled = ctl1_q.dbl ? (prod_q <<< 1) : prod_q;
    term   = ctl1_q.neg ? -scaled : scaled;
  end

  // product and accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= wide_i * nar_i;
    ctl1_q <= ctl_i;
    if (v1_q) begin
      acc_q  <= ctl1_q.clr ? term : acc_q + term;
      dst2_q <= ctl1_q.dst;
      idx2_q <= ctl1_q.dst_idx;
    end
  end

  assign acc_o        = acc_q;
  assign wb_o.valid   = v2_q;
  assign wb_o.dst     = dst2_q;
  assign wb_o.idx     = idx2_q;
  assign busy_o       = v1_q | v2_q;

endmodule

FILE: rtl/jpfk_norm.sv
// jpfk_norm: quaternion normalizer, bit-serial square root of the sum of
// squares then one restoring divide per component; depends on jpfk_pkg.
module jpfk_norm (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [jpfk_pkg::SUM_W-1:0]         s_i,
  input  logic signed [jpfk_pkg::TQW-1:0]    q_i [4],
  output logic                               done_o,
  output logic signed [jpfk_pkg::QW-1:0]     oq_o [4]
);
  import jpfk_pkg::*;

  localparam int unsigned SQ_W     = SUM_W + 16;
  localparam int unsigned SQ_ITERS = (SQ_W + 1) / 2;
  localparam int unsigned QUOT_W   = 17;
  localparam int unsigned DV_W     = 45;
  localparam int unsigned MAG_SH   = 22;

  typedef enum logic [2:0] {N_IDLE, N_SQRT, N_DPREP, N_DIV, N_FIN, N_DONE} nstate_e;

  nstate_e                 state_q;
  logic [4:0]              cnt_q;
  logic [1:0]              comp_q;
  logic [SQ_W-1:0]         x_q;
  logic [SQ_W-1:0]         res_q;
  logic [SQ_W-1:0]         bit_q;
  logic [DV_W-1:0]         rem_q;
  logic [DV_W-1:0]         dv_q;
  logic [QUOT_W-1:0]       quot_q;
  logic signed [TQW-1:0]   qc_q [4];
  logic signed [QW-1:0]    oq_q [4];
  logic [SQ_W-1:0]         trial;
  logic                    sq_ge;
  logic [TQW-1:0]          mag;
  logic signed [TQW-1:0]   qv;

  // root step compare and component magnitude
  always_comb begin
    trial = res_q + bit_q;
    sq_ge = x_q >= trial;
    mag   = qc_q[comp_q][TQW-1] ? TQW'(-qc_q[comp_q]) : TQW'(qc_q[comp_q]);
    qv    = $signed(TQW'(quot_q));
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            cnt_q   <= '0;
            comp_q  <= '0;
            state_q <= (s_i == '0) ? N_DONE : N_SQRT;
          end
        end
        N_SQRT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(SQ_ITERS - 1)) begin
            state_q <= N_DPREP;
          end
        end
        N_DPREP: begin
          cnt_q   <= '0;
          state_q <= N_DIV;
        end
        N_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(QUOT_W - 1)) begin
            state_q <= N_FIN;
          end
        end
        N_FIN: begin
          comp_q  <= comp_q + 2'd1;
          state_q <= (comp_q == 2'd3) ? N_DONE : N_DPREP;
        end
        N_DONE: state_q <= N_IDLE;
        default: state_q <= N_IDLE;
      endcase
    end
  end

  // root and divide datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          qc_q  <= q_i;
          x_q   <= {s_i, 16'b0};
          res_q <= '0;
          bit_q <= SQ_W'(1) << (SQ_W - 1);
          if (s_i == '0) begin
            for (int i = 0; i < 4; i++) begin
              oq_q[i] <= '0;
            end
          end
        end
      end
      N_SQRT: begin
        if (sq_ge) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      N_DPREP: begin
        rem_q  <= (DV_W'(mag) << MAG_SH) + DV_W'(res_q >> 1);
        dv_q   <= DV_W'(res_q) << (QUOT_W - 1);
        quot_q <= '0;
      end
      N_DIV: begin
        if (rem_q >= dv_q) begin
          rem_q  <= rem_q - dv_q;
          quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
        end else begin
          quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
        end
        dv_q <= dv_q >> 1;
      end
      N_FIN: begin
        oq_q[comp_q] <= sat16(qc_q[comp_q][TQW-1] ? -qv : qv);
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == N_DONE);
  assign oq_o   = oq_q;

endmodule

FILE: rtl/joint_pose_apply_forward_kinematics.sv
// A modification transfer only stores its delta and leaves the input ready. A root
// joint passes its pose to the output, with any pending delta applied first. A
// joint with a parent needs 42 products through the one shared multiply-accumulate,
// a 28-step square root and four 17-step divides, besides any pending delta's products.
// One item at a time; input ready returns while the result waits at the output.
// Reset clears the sequencer and the pending-delta flags; pose tables are not reset.
module joint_pose_apply_forward_kinematics (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // joint_index, parent_index, quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z
  input  logic [jpfk_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_joint, obj_w, obj_x, obj_y, obj_z, obj_px, obj_py, obj_pz
  output logic [jpfk_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import jpfk_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DQM, ST_DRAIN, ST_DADD, ST_ROT, ST_QP, ST_SQ, ST_NORM, ST_NORMW,
    ST_PASS, ST_OUT
  } state_e;

  state_e                   state_q;
  state_e                   after_q;
  logic [4:0]               step_q;
  logic [MAX_JOINTS-1:0]    pending_q;
  logic                     m_valid_q;
  logic [M_TDATA_W-1:0]     m_tdata_q;

  logic [JIDX_W-1:0]        joint_q;
  logic                     has_par_q;
  logic signed [QW-1:0]     lq_q [4];
  logic signed [PW-1:0]     lp_q [3];
  logic signed [TQW-1:0]    tq_q [4];
  logic signed [NAR_W-1:0]  a_q;
  logic signed [WIDE_W-1:0] d_q;
  logic signed [WIDE_W-1:0] c_q [3];
  logic signed [PW-1:0]     op_q [3];
  logic signed [QW-1:0]     oq_q [4];
  logic [SUM_W-1:0]         s_q;

  logic [ENTRY_W-1:0]       delta_mem [MAX_JOINTS];
  logic [ENTRY_W-1:0]       obj_mem [MAX_JOINTS];
  logic [ENTRY_W-1:0]       dmem_rd_q;
  logic [ENTRY_W-1:0]       omem_rd_q;

  logic                     accept;
  logic                     out_go;
  logic [JIDX_W-1:0]        in_joint;
  logic signed [6:0]        in_parent;
  logic                     in_has_par;
  logic signed [QW-1:0]     in_q [4];
  logic signed [PW-1:0]     in_p [3];
  logic signed [QW-1:0]     dq [4];
  logic signed [PW-1:0]     dp [3];
  logic signed [QW-1:0]     pq [4];
  logic signed [PW-1:0]     pp [3];

  uop_t                     uop;
  logic                     issue;
  logic signed [WIDE_W-1:0] wide_op;
  logic signed [NAR_W-1:0]  nar_op;
  logic signed [ACC_W-1:0]  mac_acc;
  mac_wb_t                  mac_wb;
  logic                     mac_busy;
  logic signed [ACC_W-1:0]  rnd_v;
  logic signed [SATW-1:0]   op_sum;

  logic                     norm_start;
  logic                     norm_done;
  logic signed [QW-1:0]     norm_oq [4];

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_go        = (state_q == ST_OUT) & (~m_valid_q | m_axis_tready);
  assign norm_start    = (state_q == ST_NORM);

  // input fields and table entries
  always_comb begin
    in_joint   = s_axis_tdata[JIDX_W-1:0];
    in_parent  = s_axis_tdata[12:6];
    in_has_par = ~in_parent[6] & (in_parent[JIDX_W-1:0] < in_joint);
    for (int k = 0; k < 4; k++) begin
      in_q[k] = s_axis_tdata[13 + QW * k +: QW];
      dq[k]   = dmem_rd_q[QW * k +: QW];
      pq[k]   = omem_rd_q[QW * k +: QW];
    end
    for (int i = 0; i < 3; i++) begin
      in_p[i] = s_axis_tdata[77 + PW * i +: PW];
      dp[i]   = dmem_rd_q[4 * QW + PW * i +: PW];
      pp[i]   = omem_rd_q[4 * QW + PW * i +: PW];
    end
  end

  // micro-op for the current step
  always_comb begin
    uop   = '0;
    issue = 1'b0;
    case (state_q)
      ST_DQM: begin
        uop   = qmul_uop(step_q[3:0], NK_DQ);
        issue = 1'b1;
      end
      ST_ROT: begin
        uop   = rot_uop(step_q);
        issue = 1'b1;
      end
      ST_QP: begin
        uop   = qmul_uop(step_q[3:0], NK_PQ);
        issue = 1'b1;
      end
      ST_SQ: begin
        uop   = sq_uop(step_q[1:0]);
        issue = 1'b1;
      end
      default: ;
    endcase
  end

  // operand selection
  always_comb begin
    case (uop.wk)
      WK_LQ:   wide_op = WIDE_W'(lq_q[uop.wi]);
      WK_LP:   wide_op = WIDE_W'(lp_q[uop.wi]);
      WK_PQ:   wide_op = WIDE_W'(pq[uop.wi]);
      WK_TQ:   wide_op = WIDE_W'(tq_q[uop.wi]);
      WK_D:    wide_op = d_q;
      WK_C:    wide_op = c_q[uop.wi];
      default: wide_op = '0;
    endcase
    case (uop.nk)
      NK_DQ:   nar_op = NAR_W'(dq[uop.ni]);
      NK_PQ:   nar_op = NAR_W'(pq[uop.ni]);
      NK_TQ:   nar_op = tq_q[uop.ni];
      NK_A:    nar_op = a_q;
      default: nar_op = '0;
    endcase
  end

  jpfk_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .ctl_i   (uop.ctl),
    .wide_i  (wide_op),
    .nar_i   (nar_op),
    .acc_o   (mac_acc),
    .wb_o    (mac_wb),
    .busy_o  (mac_busy)
  );

  jpfk_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .s_i     (s_q),
    .q_i     (tq_q),
    .done_o  (norm_done),
    .oq_o    (norm_oq)
  );

  // rounding of the finished sum, parent position added for rotated terms
  always_comb begin
    rnd_v  = (mac_acc + RND_HALF) >>> RND_SH;
    op_sum = $signed(rnd_v[SATW-1:0]) + SATW'(pp[mac_wb.idx]);
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      after_q   <= ST_IDLE;
      step_q    <= '0;
      pending_q <= '0;
      m_valid_q <= 1'b0;
      m_tdata_q <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_go) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (s_axis_tvalid) begin
            if (!s_axis_tuser) begin
              pending_q[in_joint] <= 1'b1;
            end else begin
              pending_q[in_joint] <= 1'b0;
              if (pending_q[in_joint]) begin
                state_q <= ST_DQM;
              end else if (in_has_par) begin
                state_q <= ST_ROT;
              end else begin
                state_q <= ST_PASS;
              end
            end
          end
        end
        ST_DQM: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(QMUL_STEPS - 1)) begin
            state_q <= ST_DRAIN;
            after_q <= ST_DADD;
          end
        end
        ST_DRAIN: begin
          step_q <= '0;
          if (!mac_busy) begin
            state_q <= after_q;
          end
        end
        ST_DADD: begin
          step_q  <= '0;
          state_q <= has_par_q ? ST_ROT : ST_PASS;
        end
        ST_ROT: begin
          if (step_q == 5'(ROT_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= ST_QP;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_QP: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(QMUL_STEPS - 1)) begin
            state_q <= ST_DRAIN;
            after_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(SQ_STEPS - 1)) begin
            state_q <= ST_DRAIN;
            after_q <= ST_NORM;
          end
        end
        ST_NORM:  state_q <= ST_NORMW;
        ST_NORMW: begin
          if (norm_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_PASS:  state_q <= ST_OUT;
        ST_OUT: begin
          if (out_go) begin
            m_valid_q <= 1'b1;
            m_tdata_q <= {2'b00, op_q[2], op_q[1], op_q[0],
                          oq_q[3], oq_q[2], oq_q[1], oq_q[0], joint_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // operand registers and write-back
  always_ff @(posedge clk_i) begin
    if (accept) begin
      joint_q   <= in_joint;
      has_par_q <= in_has_par;
      lq_q      <= in_q;
      lp_q      <= in_p;
    end
    if (mac_wb.valid) begin
      case (mac_wb.dst)
        DK_TQ:   tq_q[mac_wb.idx] <= rnd_v[TQW-1:0];
        DK_A:    a_q <= rnd_v[NAR_W-1:0];
        DK_D:    d_q <= rnd_v[WIDE_W-1:0];
        DK_C:    c_q[mac_wb.idx] <= rnd_v[WIDE_W-1:0];
        DK_OP:   op_q[mac_wb.idx] <= sat32(op_sum);
        DK_S:    s_q <= mac_acc[SUM_W-1:0];
        default: ;
      endcase
    end
    if (state_q == ST_DADD) begin
      for (int k = 0; k < 4; k++) begin
        lq_q[k] <= sat16(tq_q[k]);
      end
      for (int i = 0; i < 3; i++) begin
        lp_q[i] <= sat32(SATW'(lp_q[i]) + SATW'(dp[i]));
      end
    end
    if (state_q == ST_PASS) begin
      oq_q <= lq_q;
      op_q <= lp_q;
    end
    if (state_q == ST_NORMW && norm_done) begin
      oq_q <= norm_oq;
    end
  end

  // delta and object pose tables
  always_ff @(posedge clk_i) begin
    if (accept && !s_axis_tuser) begin
      delta_mem[in_joint] <= s_axis_tdata[13 +: ENTRY_W];
    end
    if (accept) begin
      dmem_rd_q <= delta_mem[in_joint];
      omem_rd_q <= obj_mem[in_parent[JIDX_W-1:0]];
    end
    if (out_go) begin
      obj_mem[joint_q] <= {op_q[2], op_q[1], op_q[0], oq_q[3], oq_q[2], oq_q[1], oq_q[0]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

FILE: rtl/jpfk_checker.sv
// jpfk_checker: port-level assertions for the forward kinematics block,
// bound to the top level below; depends on jpfk_pkg.
module jpfk_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [jpfk_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [jpfk_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import jpfk_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a joint transfer keeps the block busy the next cycle
  a_joint_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("ready right after a joint transfer");

  // a modification never produces a result
  a_mod_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after a modification");

  // a modification leaves the block ready
  a_mod_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("modification stalled the input");

endmodule

bind joint_pose_apply_forward_kinematics jpfk_checker u_jpfk_checker (.*);
